// File: src/vna_pkg.sv
// shared codes and widths for the vertex normal accumulator
package vna_pkg;

	localparam int CRN_W = 11;
	localparam int VN_W  = 10;
	localparam int NRM_W = 16;
	localparam int MUL_W = 32;

	localparam logic signed [NRM_W-1:0] NRM_ONE = 16'sd16384;

	typedef enum logic [1:0] {
		MODE_VERTEX = 2'd0,
		MODE_FACE   = 2'd1,
		MODE_READ   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

endpackage

// File: src/vna_ram.sv
// generic single write port ram with registered read
module vna_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/vertex_normal_accumulator_core.sv
// top level: vertex store, face normal accumulation and normalized readout
//
// The block keeps up to VERTEX_CAPACITY vertex positions (signed Q8.8) in one
// ram and the per-vertex normal sums (three signed SUM_BITS words) in a second
// ram. A request is taken only while the sequencer is idle and gives exactly
// one result; a finished result waits in the output register while the next
// request is taken. Add vertex goes straight to the done state and the output
// register. Add face reads three corners, forms the cross product on the one
// shared 32x32 multiplier, and does a read-modify-write of the sum ram for
// each corner. Read reads the sum, shifts it one bit at a time into the
// normalizing window, forms the squares on the shared multiplier, then runs
// the bit-serial square root and a bit-serial divide per component; a read of
// a zero sum goes straight to the done state. The rate is set by these serial
// units and the single read port.
// A bad corner, bad corner count, unknown mode or full store goes straight to
// the done state. Sums saturate to the signed SUM_BITS range; a zero sum reads
// as zero.
module vertex_normal_accumulator_core import vna_pkg::*; #(
	parameter int VERTEX_CAPACITY = 1024,
	parameter int COORD_BITS      = 16,
	parameter int SUM_BITS        = 40
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic [1:0]                   mode,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic signed [COORD_BITS-1:0] coord_z,
	input  logic [CRN_W-1:0]             corner_a,
	input  logic [CRN_W-1:0]             corner_b,
	input  logic [CRN_W-1:0]             corner_c,
	input  logic [CRN_W-1:0]             corner_d,
	input  logic [2:0]                   corner_count,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic signed [NRM_W-1:0]      normal_x,
	output logic signed [NRM_W-1:0]      normal_y,
	output logic signed [NRM_W-1:0]      normal_z,
	output logic [VN_W-1:0]              vertex_number,
	output logic [1:0]                   status
);

	localparam int AW   = $clog2(VERTEX_CAPACITY);
	localparam int TW   = $clog2(VERTEX_CAPACITY + 1);
	localparam int DW   = COORD_BITS + 1;             // coordinate difference
	localparam int CW   = 2 * DW + 1;                 // cross product component
	localparam int ADW  = (SUM_BITS > CW ? SUM_BITS : CW) + 1;
	localparam int MW   = SUM_BITS > 31 ? SUM_BITS : 31;
	localparam int NW   = 47;                         // divide numerator
	localparam int QW   = 15;                         // quotient bits

	typedef enum logic [15:0] {
		S_IDLE = 16'b0000_0000_0000_0001,
		S_PRD  = 16'b0000_0000_0000_0010,
		S_PCAP = 16'b0000_0000_0000_0100,
		S_XMUL = 16'b0000_0000_0000_1000,
		S_XACC = 16'b0000_0000_0001_0000,
		S_SRD  = 16'b0000_0000_0010_0000,
		S_SWR  = 16'b0000_0000_0100_0000,
		S_NRD  = 16'b0000_0000_1000_0000,
		S_NCAP = 16'b0000_0001_0000_0000,
		S_NSHF = 16'b0000_0010_0000_0000,
		S_SQM  = 16'b0000_0100_0000_0000,
		S_SQA  = 16'b0000_1000_0000_0000,
		S_ROOT = 16'b0001_0000_0000_0000,
		S_DIVI = 16'b0010_0000_0000_0000,
		S_DIV  = 16'b0100_0000_0000_0000,
		S_DONE = 16'b1000_0000_0000_0000
	} state_t;

	// control
	state_t           state_q;
	logic [TW-1:0]    total_q;
	logic [2:0]       step_q;
	logic [4:0]       iter_q;
	logic             res_valid_q;

	// request and datapath
	logic [AW-1:0]              caddr_q [4];
	logic                       quad_q;
	logic signed [COORD_BITS-1:0] p_q [3][3];
	logic signed [CW-1:0]       cross_q [3];
	logic signed [2*MUL_W-1:0]  prod_q;
	logic                       sgn_q [3];
	logic [MW-1:0]              mag_q [3];
	logic [63:0]                sq_q;
	logic [63:0]                x_q;
	logic [63:0]                rt_q;
	logic [63:0]                bit_q;
	logic [NW-1:0]              rem_q;
	logic [NW-1:0]              dsh_q;
	logic [QW-1:0]              quo_q;
	logic signed [NRM_W-1:0]    nrm_q [3];
	logic [VN_W-1:0]            vn_q;
	logic [1:0]                 st_q;

	// output register
	logic signed [NRM_W-1:0]    out_nrm_q [3];
	logic [VN_W-1:0]            out_vn_q;
	logic [1:0]                 out_st_q;

	// rams
	logic                   pos_we;
	logic [AW-1:0]          pos_raddr;
	logic [3*COORD_BITS-1:0] pos_rdata;
	logic                   sum_we;
	logic [AW-1:0]          sum_waddr;
	logic [AW-1:0]          sum_raddr;
	logic [3*SUM_BITS-1:0]  sum_wdata;
	logic [3*SUM_BITS-1:0]  sum_rdata;

	logic                   accept;
	logic                   full;
	logic                   face_ok;
	logic                   read_ok;
	logic                   last_corner;
	logic                   emit;
	logic signed [SUM_BITS-1:0] rd_sum [3];
	logic signed [DW-1:0]   u_d [3];
	logic signed [DW-1:0]   v_d [3];
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	logic                   any_hi;
	logic                   all_lo;
	logic [63:0]            rt_try;
	logic [31:0]            root;
	logic [QW-1:0]          quo_nx;
	logic                   div_ge;

	function automatic logic corner_ok(input logic [CRN_W-1:0] c, input logic [TW-1:0] t);
		logic [CRN_W+TW-1:0] ce;
		logic [CRN_W+TW-1:0] te;
		ce = {{TW{1'b0}}, c};
		te = {{CRN_W{1'b0}}, t};
		return (c != '0) && (ce <= te);
	endfunction

	function automatic logic [AW-1:0] to_addr(input logic [CRN_W-1:0] c);
		logic [CRN_W-1:0]    cm;
		logic [CRN_W+AW-1:0] ext;
		cm  = c - CRN_W'(1);
		ext = {{AW{1'b0}}, cm};
		return ext[AW-1:0];
	endfunction

	function automatic logic [VN_W-1:0] to_vn(input logic [AW-1:0] a);
		logic [AW+VN_W-1:0] ext;
		ext = {{VN_W{1'b0}}, a};
		return ext[VN_W-1:0];
	endfunction

	// add a face normal component to a stored sum, clamped to the sum range
	function automatic logic [SUM_BITS-1:0] sat_add(input logic signed [SUM_BITS-1:0] s,
	                                                input logic signed [CW-1:0] c);
		logic signed [ADW-1:0] w;
		logic                  fits;
		w    = ADW'(s) + ADW'(c);
		fits = (&w[ADW-1:SUM_BITS-1]) || !(|w[ADW-1:SUM_BITS-1]);
		if (fits) begin
			return w[SUM_BITS-1:0];
		end
		return w[ADW-1] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
	endfunction

	vna_ram #(.WIDTH(3*COORD_BITS), .DEPTH(VERTEX_CAPACITY)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (total_q[AW-1:0]),
		.wdata ({coord_z, coord_y, coord_x}),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	vna_ram #(.WIDTH(3*SUM_BITS), .DEPTH(VERTEX_CAPACITY)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign full      = (total_q == TW'(VERTEX_CAPACITY));

	// a face needs a legal count and every named corner in range
	assign face_ok = ((corner_count == 3'd3) || (corner_count == 3'd4)) &&
	                 corner_ok(corner_a, total_q) && corner_ok(corner_b, total_q) &&
	                 corner_ok(corner_c, total_q) &&
	                 ((corner_count != 3'd4) || corner_ok(corner_d, total_q));
	assign read_ok = corner_ok(corner_a, total_q);

	assign last_corner = quad_q ? (step_q == 3'd3) : (step_q == 3'd2);
	assign emit        = (state_q == S_DONE) && (!res_valid_q || res_ready);

	// ram port steering
	assign pos_we    = accept && (mode == MODE_VERTEX) && !full;
	assign pos_raddr = caddr_q[step_q[1:0]];

	always_comb begin
		sum_we    = 1'b0;
		sum_waddr = caddr_q[step_q[1:0]];
		sum_wdata = '0;
		sum_raddr = caddr_q[step_q[1:0]];
		if (pos_we) begin
			// new vertex starts with a cleared sum
			sum_we    = 1'b1;
			sum_waddr = total_q[AW-1:0];
		end else if (state_q == S_SWR) begin
			sum_we    = 1'b1;
			sum_wdata = {sat_add(rd_sum[2], cross_q[2]),
			             sat_add(rd_sum[1], cross_q[1]),
			             sat_add(rd_sum[0], cross_q[0])};
		end
		if (state_q == S_NRD) begin
			sum_raddr = caddr_q[0];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rd_sum[i] = sum_rdata[i*SUM_BITS +: SUM_BITS];
			u_d[i]    = DW'(p_q[1][i]) - DW'(p_q[0][i]);
			v_d[i]    = DW'(p_q[2][i]) - DW'(p_q[1][i]);
		end
	end

	// shared multiplier operands: cross product terms or squared magnitudes
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_SQM) begin
			mul_a = $signed({{(MUL_W-30){1'b0}}, mag_q[step_q[1:0]][29:0]});
			mul_b = mul_a;
		end else begin
			case (step_q)
				3'd0: begin mul_a = MUL_W'(u_d[1]); mul_b = MUL_W'(v_d[2]); end
				3'd1: begin mul_a = MUL_W'(u_d[2]); mul_b = MUL_W'(v_d[1]); end
				3'd2: begin mul_a = MUL_W'(u_d[2]); mul_b = MUL_W'(v_d[0]); end
				3'd3: begin mul_a = MUL_W'(u_d[0]); mul_b = MUL_W'(v_d[2]); end
				3'd4: begin mul_a = MUL_W'(u_d[0]); mul_b = MUL_W'(v_d[1]); end
				3'd5: begin mul_a = MUL_W'(u_d[1]); mul_b = MUL_W'(v_d[0]); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	// normalizing window is [2^29, 2^30) on the largest magnitude
	always_comb begin
		any_hi = 1'b0;
		all_lo = 1'b1;
		for (int i = 0; i < 3; i++) begin
			any_hi = any_hi | (|mag_q[i][MW-1:30]);
			all_lo = all_lo & !(|mag_q[i][MW-1:29]);
		end
	end

	assign rt_try = rt_q + bit_q;
	assign root   = rt_q[31:0];
	assign div_ge = (rem_q >= dsh_q);
	assign quo_nx = {quo_q[QW-2:0], div_ge};

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			total_q     <= '0;
			step_q      <= '0;
			iter_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (accept) begin
						if (pos_we) begin
							total_q <= total_q + TW'(1);
							state_q <= S_DONE;
						end else if (mode == MODE_FACE && face_ok) begin
							state_q <= S_PRD;
						end else if (mode == MODE_READ && read_ok) begin
							state_q <= S_NRD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_PRD: state_q <= S_PCAP;
				S_PCAP: begin
					if (step_q == 3'd2) begin
						step_q  <= '0;
						state_q <= S_XMUL;
					end else begin
						step_q  <= step_q + 3'd1;
						state_q <= S_PRD;
					end
				end
				S_XMUL: state_q <= S_XACC;
				S_XACC: begin
					if (step_q == 3'd5) begin
						step_q  <= '0;
						state_q <= S_SRD;
					end else begin
						step_q  <= step_q + 3'd1;
						state_q <= S_XMUL;
					end
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: begin
					if (last_corner) begin
						state_q <= S_DONE;
					end else begin
						step_q  <= step_q + 3'd1;
						state_q <= S_SRD;
					end
				end
				S_NRD: state_q <= S_NCAP;
				S_NCAP: begin
					if (rd_sum[0] == '0 && rd_sum[1] == '0 && rd_sum[2] == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_NSHF;
					end
				end
				S_NSHF: begin
					if (!any_hi && !all_lo) begin
						step_q  <= '0;
						state_q <= S_SQM;
					end
				end
				S_SQM: state_q <= S_SQA;
				S_SQA: begin
					if (step_q == 3'd2) begin
						iter_q  <= '0;
						state_q <= S_ROOT;
					end else begin
						step_q  <= step_q + 3'd1;
						state_q <= S_SQM;
					end
				end
				S_ROOT: begin
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'd31) begin
						step_q  <= '0;
						state_q <= S_DIVI;
					end
				end
				S_DIVI: begin
					iter_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'(QW - 1)) begin
						if (step_q == 3'd2) begin
							state_q <= S_DONE;
						end else begin
							step_q  <= step_q + 3'd1;
							state_q <= S_DIVI;
						end
					end
				end
				S_DONE: begin
					if (emit) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			caddr_q[0] <= to_addr(corner_a);
			caddr_q[1] <= to_addr(corner_b);
			caddr_q[2] <= to_addr(corner_c);
			caddr_q[3] <= to_addr(corner_d);
			quad_q     <= (corner_count == 3'd4);
			for (int i = 0; i < 3; i++) begin
				nrm_q[i] <= '0;
			end
			case (mode)
				MODE_VERTEX: begin
					st_q <= full ? ST_FULL : ST_OK;
					vn_q <= full ? '0 : to_vn(total_q[AW-1:0]);
				end
				MODE_FACE: begin
					st_q <= face_ok ? ST_OK : ST_RANGE;
					vn_q <= face_ok ? to_vn(to_addr(corner_a)) : '0;
				end
				MODE_READ: begin
					st_q <= read_ok ? ST_OK : ST_RANGE;
					vn_q <= read_ok ? to_vn(to_addr(corner_a)) : '0;
				end
				default: begin
					st_q <= ST_RANGE;
					vn_q <= '0;
				end
			endcase
		end
		case (state_q)
			S_PCAP: begin
				for (int i = 0; i < 3; i++) begin
					p_q[step_q[1:0]][i] <= pos_rdata[i*COORD_BITS +: COORD_BITS];
				end
			end
			S_XACC: begin
				if (step_q[0]) begin
					cross_q[step_q[2:1]] <= cross_q[step_q[2:1]] - $signed(prod_q[CW-1:0]);
				end else begin
					cross_q[step_q[2:1]] <= $signed(prod_q[CW-1:0]);
				end
			end
			S_NCAP: begin
				for (int i = 0; i < 3; i++) begin
					sgn_q[i] <= rd_sum[i][SUM_BITS-1];
					mag_q[i] <= MW'(rd_sum[i][SUM_BITS-1] ? (~rd_sum[i] + SUM_BITS'(1))
					                                      : rd_sum[i]);
				end
				sq_q <= '0;
			end
			S_NSHF: begin
				for (int i = 0; i < 3; i++) begin
					if (any_hi) begin
						mag_q[i] <= mag_q[i] >> 1;
					end else if (all_lo) begin
						mag_q[i] <= mag_q[i] << 1;
					end
				end
			end
			S_SQA: begin
				sq_q  <= sq_q + $unsigned(prod_q);
				x_q   <= sq_q + $unsigned(prod_q);
				rt_q  <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			S_ROOT: begin
				// one result bit per cycle, restoring square root
				if (x_q >= rt_try) begin
					x_q  <= x_q - rt_try;
					rt_q <= (rt_q >> 1) + bit_q;
				end else begin
					rt_q <= rt_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DIVI: begin
				// (mag * 32768 + r) / (2 r) rounds half away from zero
				rem_q <= (NW'(mag_q[step_q[1:0]][29:0]) << 15) + NW'(root);
				dsh_q <= NW'({root, 1'b0}) << (QW - 1);
				quo_q <= '0;
			end
			S_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_nx;
				if (iter_q == 5'(QW - 1)) begin
					nrm_q[step_q[1:0]] <= sgn_q[step_q[1:0]] ? -NRM_W'(quo_nx) : NRM_W'(quo_nx);
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			for (int i = 0; i < 3; i++) begin
				out_nrm_q[i] <= nrm_q[i];
			end
			out_vn_q <= vn_q;
			out_st_q <= st_q;
		end
	end

	assign res_valid     = res_valid_q;
	assign normal_x      = out_nrm_q[0];
	assign normal_y      = out_nrm_q[1];
	assign normal_z      = out_nrm_q[2];
	assign vertex_number = out_vn_q;
	assign status        = out_st_q;

endmodule

// File: src/vna_checker.sv
// port level checks for the vertex normal accumulator
module vna_checker import vna_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    res_valid,
	input logic                    res_ready,
	input logic signed [NRM_W-1:0] normal_x,
	input logic signed [NRM_W-1:0] normal_y,
	input logic signed [NRM_W-1:0] normal_z,
	input logic [VN_W-1:0]         vertex_number,
	input logic [1:0]              status
);

	// status never carries the unused code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (status == ST_OK || status == ST_FULL || status == ST_RANGE))
		else $error("unused status code on result");

	// an error result carries no normal and no vertex number
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != ST_OK) |->
		(normal_x == '0 && normal_y == '0 && normal_z == '0 && vertex_number == '0))
		else $error("error result with nonzero payload");

	// normalized components stay within unit length
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (normal_x >= -NRM_ONE && normal_x <= NRM_ONE &&
		               normal_y >= -NRM_ONE && normal_y <= NRM_ONE &&
		               normal_z >= -NRM_ONE && normal_z <= NRM_ONE))
		else $error("normal component out of range");

	// a stalled result holds its valid, status, vertex number and normal_x
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(status) &&
		                               $stable(vertex_number) && $stable(normal_x)))
		else $error("result changed while stalled");

endmodule

bind vertex_normal_accumulator_core vna_checker u_vna_checker (.*);

// File: bench/vertex_normal_accumulator_core_tb.sv
// testbench for vertex_normal_accumulator_core: directed and random mesh traffic vs a local model
`timescale 1ns / 100ps

module vertex_normal_accumulator_core_tb;
	import vna_pkg::*;

	localparam int CAPACITY = 1024;
	localparam int SUM_W = 40;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		mode_t mode;
		logic signed [15:0] x, y, z;
		logic [CRN_W-1:0] a, b, c, d;
		logic [2:0] cnt;
	} mesh_req_t;

	typedef struct {
		logic [NRM_W-1:0] nx, ny, nz;
		logic [VN_W-1:0] vnum;
		status_t st;
	} mesh_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [1:0] mode = '0;
	logic signed [15:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic [CRN_W-1:0] corner_a = '0, corner_b = '0, corner_c = '0, corner_d = '0;
	logic [2:0] corner_count = 3'd3;
	logic res_valid;
	logic res_ready = 1'b0;
	logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
	logic [VN_W-1:0] vertex_number;
	logic [1:0] status;

	vertex_normal_accumulator_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state of the mesh
	int px[CAPACITY], py[CAPACITY], pz[CAPACITY];
	longint sum_x[CAPACITY], sum_y[CAPACITY], sum_z[CAPACITY];
	int vertex_count = 0;
	mesh_res_t pending_normals[$];
	int failures = 0;
	int cycles = 0;
	int n_vertex = 0, n_face = 0, n_read = 0, n_reject = 0;
	int burst_left = 0;

	function automatic longint clamp_sum(longint v);
		longint hi;
		hi = (64'sd1 <<< (SUM_W - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// scale a sum to unit length in Q1.14, rounding half away from zero
	function automatic void unit_normal(longint s[3], output logic [NRM_W-1:0] o[3]);
		logic [63:0] m[3], big, r, q;
		longint sq;
		for (int i = 0; i < 3; i++) m[i] = (s[i] < 0) ? -s[i] : s[i];
		big = m[0];
		if (m[1] > big) big = m[1];
		if (m[2] > big) big = m[2];
		if (big == 0) begin
			for (int i = 0; i < 3; i++) o[i] = '0;
			return;
		end
		while (big >= (64'd1 << 30)) begin
			big >>= 1;
			for (int i = 0; i < 3; i++) m[i] >>= 1;
		end
		while (big < (64'd1 << 29)) begin
			big <<= 1;
			for (int i = 0; i < 3; i++) m[i] <<= 1;
		end
		r = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 64'd32768 + r) / (64'd2 * r);
			sq = (s[i] < 0) ? -longint'(q) : longint'(q);
			o[i] = sq[NRM_W-1:0];
		end
	endfunction

	function automatic bit corner_valid(logic [CRN_W-1:0] c);
		return c >= 1 && c <= vertex_count;
	endfunction

	// update the mesh model with one request and return its result
	function automatic mesh_res_t apply_request(mesh_req_t r);
		mesh_res_t e;
		logic [CRN_W-1:0] cr[4];
		int n, ia, ib, ic, k;
		bit ok;
		longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
		longint s[3];
		logic [NRM_W-1:0] o[3];
		e.nx = '0;
		e.ny = '0;
		e.nz = '0;
		e.vnum = '0;
		e.st = ST_OK;
		cr = '{r.a, r.b, r.c, r.d};
		case (r.mode)
			MODE_VERTEX: begin
				if (vertex_count >= CAPACITY) begin
					e.st = ST_FULL;
				end else begin
					k = vertex_count;
					px[k] = int'(r.x);
					py[k] = int'(r.y);
					pz[k] = int'(r.z);
					sum_x[k] = 0;
					sum_y[k] = 0;
					sum_z[k] = 0;
					vertex_count++;
					e.vnum = VN_W'(k);
				end
			end
			MODE_FACE: begin
				n = (r.cnt == 4) ? 4 : 3;
				ok = (r.cnt == 3 || r.cnt == 4);
				for (int i = 0; i < n; i++) if (!corner_valid(cr[i])) ok = 0;
				if (!ok) begin
					e.st = ST_RANGE;
				end else begin
					ia = r.a - 1;
					ib = r.b - 1;
					ic = r.c - 1;
					ux = longint'(px[ib]) - longint'(px[ia]);
					uy = longint'(py[ib]) - longint'(py[ia]);
					uz = longint'(pz[ib]) - longint'(pz[ia]);
					vx = longint'(px[ic]) - longint'(px[ib]);
					vy = longint'(py[ic]) - longint'(py[ib]);
					vz = longint'(pz[ic]) - longint'(pz[ib]);
					cx = uy * vz - uz * vy;
					cy = uz * vx - ux * vz;
					cz = ux * vy - uy * vx;
					for (int i = 0; i < n; i++) begin
						k = cr[i] - 1;
						sum_x[k] = clamp_sum(sum_x[k] + cx);
						sum_y[k] = clamp_sum(sum_y[k] + cy);
						sum_z[k] = clamp_sum(sum_z[k] + cz);
					end
					e.vnum = VN_W'(ia);
				end
			end
			MODE_READ: begin
				if (!corner_valid(r.a)) begin
					e.st = ST_RANGE;
				end else begin
					k = r.a - 1;
					s = '{sum_x[k], sum_y[k], sum_z[k]};
					unit_normal(s, o);
					e.nx = o[0];
					e.ny = o[1];
					e.nz = o[2];
					e.vnum = VN_W'(k);
				end
			end
			default: e.st = ST_RANGE;
		endcase
		return e;
	endfunction

	// one request: optional gap, then hold valid until taken
	task automatic send_request(mesh_req_t r);
		int gap;
		mesh_res_t e;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
		end
		burst_left--;
		if (gap > 0) begin
			@(negedge clk);
			req_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid = 1'b1;
		mode = r.mode;
		coord_x = r.x;
		coord_y = r.y;
		coord_z = r.z;
		corner_a = r.a;
		corner_b = r.b;
		corner_c = r.c;
		corner_d = r.d;
		corner_count = r.cnt;
		do @(posedge clk); while (!req_ready);
		e = apply_request(r);
		pending_normals.push_back(e);
		case (e.st)
			ST_OK: begin
				if (r.mode == MODE_VERTEX) n_vertex++;
				else if (r.mode == MODE_FACE) n_face++;
				else n_read++;
			end
			default: n_reject++;
		endcase
	endtask

	task automatic wait_idle();
		@(negedge clk);
		req_valid = 1'b0;
		wait (pending_normals.size() == 0);
	endtask

	function automatic mesh_req_t make_req(mode_t m, int x, int y, int z,
			int a, int b, int c, int d, int cnt);
		mesh_req_t r;
		r.mode = m;
		r.x = 16'(x);
		r.y = 16'(y);
		r.z = 16'(z);
		r.a = CRN_W'(a);
		r.b = CRN_W'(b);
		r.c = CRN_W'(c);
		r.d = CRN_W'(d);
		r.cnt = 3'(cnt);
		return r;
	endfunction

	task automatic add_vertex(int x, int y, int z);
		send_request(make_req(MODE_VERTEX, x, y, z, 0, 0, 0, 0, 3));
	endtask

	task automatic add_face(int a, int b, int c, int d, int cnt);
		send_request(make_req(MODE_FACE, 0, 0, 0, a, b, c, d, cnt));
	endtask

	task automatic read_normal(int a);
		send_request(make_req(MODE_READ, 0, 0, 0, a, 0, 0, 0, 3));
	endtask

	// extremes, every mode and the special cases on a tiny mesh
	task automatic test_directed();
		read_normal(0);
		read_normal(1);
		add_face(1, 1, 1, 1, 3);
		add_vertex(-32768, -32768, 32767);
		add_vertex(32767, -32768, 0);
		add_vertex(32767, 32767, -32768);
		add_vertex(0, 0, 0);
		add_vertex(256, 512, 768);
		read_normal(4);
		add_face(1, 2, 3, 0, 3);
		add_face(1, 2, 3, 4, 4);
		add_face(4, 4, 5, 4, 4);
		add_face(1, 2, 3, 0, 4);
		add_face(1, 2, 6, 0, 3);
		add_face(1, 2, 3, 4, 0);
		add_face(1, 2, 3, 4, 5);
		add_face(1, 2, 3, 4, 7);
		add_face(2047, 1, 2, 3, 3);
		send_request(make_req(MODE_NONE, -1, -1, -1, 2047, 2047, 2047, 2047, 7));
		for (int i = 1; i <= 5; i++) read_normal(i);
		read_normal(6);
		read_normal(2047);
		wait_idle();
	endtask

	// drive vertex sums into both saturation rails
	task automatic test_saturation();
		int base;
		base = vertex_count;
		add_vertex(-32768, -32768, 0);
		add_vertex(32767, -32768, 0);
		add_vertex(32767, 32767, 0);
		for (int i = 0; i < 70; i++) add_face(base + 1, base + 2, base + 3, base + 1, 4);
		read_normal(base + 1);
		read_normal(base + 2);
		for (int i = 0; i < 150; i++) add_face(base + 3, base + 2, base + 1, base + 3, 4);
		read_normal(base + 3);
		read_normal(base + 1);
		wait_idle();
	endtask

	function automatic int rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 65535) - 32768;
			1: return $urandom_range(0, 31) - 16;
			2: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
			default: return $urandom_range(0, 4095) - 2048;
		endcase
	endfunction

	function automatic int rand_corner();
		return $urandom_range(1, vertex_count);
	endfunction

	// mostly well formed faces over a growing mesh, some reads and noise
	task automatic test_random_mesh(int n_items);
		int pick, a, b, c, d;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (vertex_count < 3 || (pick < 22 && vertex_count < 1000)) begin
				add_vertex(rand_coord(), rand_coord(), rand_coord());
			end else if (pick < 65) begin
				a = rand_corner();
				b = rand_corner();
				c = rand_corner();
				d = ($urandom_range(0, 7) == 0) ? a : rand_corner();
				add_face(a, b, c, d, $urandom_range(3, 4));
			end else if (pick < 90) begin
				read_normal(rand_corner());
			end else begin
				send_request(make_req(mode_t'($urandom_range(0, 3)),
					$urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
					$urandom_range(0, 65535) - 32768,
					$urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 7)));
			end
		end
		wait_idle();
	endtask

	// fill the store, then hit the full and top-index cases
	task automatic test_store_full();
		while (vertex_count < CAPACITY) begin
			add_vertex(rand_coord(), rand_coord(), rand_coord());
			if ($urandom_range(0, 31) == 0)
				add_face(vertex_count, rand_corner(), rand_corner(), 0, 3);
		end
		add_vertex(1, 2, 3);
		add_vertex(-32768, 32767, -1);
		add_face(1024, 1023, 1, 1024, 4);
		add_face(1024, 1, 2, 1025, 4);
		read_normal(1024);
		read_normal(1023);
		read_normal(1025);
		read_normal(2047);
		wait_idle();
	endtask

	// receiver stalls in phases: none, light, heavy
	always @(negedge clk) begin
		case ((cycles / 512) % 3)
			0: res_ready = 1'b1;
			1: res_ready = ($urandom_range(0, 3) != 0);
			default: res_ready = ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		mesh_res_t e;
		if (arst_n && res_valid && res_ready) begin
			if (pending_normals.size() == 0) begin
				$error("result with nothing pending: vertex_number=%0d status=%0d",
					vertex_number, status);
				failures++;
			end else begin
				e = pending_normals.pop_front();
				if (normal_x !== e.nx) begin
					$error("normal_x expected %h got %h", e.nx, normal_x);
					failures++;
				end
				if (normal_y !== e.ny) begin
					$error("normal_y expected %h got %h", e.ny, normal_y);
					failures++;
				end
				if (normal_z !== e.nz) begin
					$error("normal_z expected %h got %h", e.nz, normal_z);
					failures++;
				end
				if (vertex_number !== e.vnum) begin
					$error("vertex_number expected %0d got %0d", e.vnum, vertex_number);
					failures++;
				end
				if (status !== e.st) begin
					$error("status expected %0d got %0d", e.st, status);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_normals.size());
			$display("vertex_normal_accumulator_core verification failed");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_saturation();
		test_random_mesh(60);
		test_store_full();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_normals.size() != 0) begin
			$error("%0d expected results never arrived", pending_normals.size());
			failures++;
		end
		$display("covered %0d vertex adds, %0d faces, %0d reads, %0d rejected requests",
			n_vertex, n_face, n_read, n_reject);
		$display("store filled to %0d vertices in %0d cycles", vertex_count, cycles);
		if (failures == 0) begin
			$display("vertex_normal_accumulator_core verification clean");
		end else begin
			$display("vertex_normal_accumulator_core verification failed");
		end
		$finish;
	end

endmodule
